>>> rtl/fsm_ff_pkg.sv
`default_nettype none
package fsm_ff_pkg;
    localparam int MAX_PAGES   = 4096;
    localparam int PAGE_W      = $clog2(MAX_PAGES);
    localparam int LANES       = 16;
    localparam int LANE_W      = $clog2(LANES);
    localparam int WORDS       = MAX_PAGES / LANES;
    localparam int WADDR_W     = $clog2(WORDS);
    localparam int BYTES_W     = 20;
    localparam int COUNT_W     = 13;
    localparam int CLASS_W     = 4;
    localparam int WORD_W      = LANES * CLASS_W;

    localparam logic [0:0] CFG_USABLE = 1'b0;
    localparam logic [0:0] CFG_PAGES  = 1'b1;
    localparam logic       MODE_UPDATE = 1'b0;
    localparam logic [CLASS_W-1:0] CLASS_FREE = 4'hf;

    function automatic logic [BYTES_W-1:0] class_threshold(
        input logic [BYTES_W-1:0] top, input logic [CLASS_W-1:0] cls);
        logic [BYTES_W-1:0] half;
        logic [BYTES_W-1:0] step;
        logic [BYTES_W+3:0] prod;
        half = top >> 1;
        step = half >> 3;
        prod = {{(4){1'b0}}, step} * {{(BYTES_W){1'b0}}, ~cls[2:0]};
        if (cls[3]) begin
            class_threshold = top - prod[BYTES_W-1:0];
        end else if (cls == '0) begin
            class_threshold = '0;
        end else begin
            class_threshold = half >> (3'd7 - cls[2:0]);
        end
    endfunction

    function automatic logic [CLASS_W-1:0] encode_class(
        input logic [BYTES_W-1:0] top, input logic [BYTES_W-1:0] bytes);
        logic [CLASS_W-1:0] res;
        res = '0;
        for (int c = 1; c < 16; c++) begin
            if (bytes >= class_threshold(top, CLASS_W'(c))) begin
                res = CLASS_W'(c);
            end
        end
        encode_class = res;
    endfunction
endpackage
`default_nettype wire

>>> rtl/fsm_ff_ram.sv
`default_nettype none
module fsm_ff_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/free_space_map_first_fit.sv
// Update: the word is read and checked, and the class is written back if the page lies
// below the page limit; it gives no result, and the next request is taken back in idle.
// Find: each 16-page memory word is read, then checked, until a fit or the page limit; the
// result is registered also with no fit or on an empty table. One request in flight.
// Reset: aresetn synchronous, active low; afterwards a clearing pass over all 256 words
// writes every class to 15 while no request is accepted.
`default_nettype none
module free_space_map_first_fit
    import fsm_ff_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [11:0]          s_page_index,
    input  wire logic [19:0]          s_free_space,
    input  wire logic [19:0]          s_required_space,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_found,
    output logic [12:0]               m_chosen_page,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [19:0]          cfg_data
);
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CHECK = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [BYTES_W-1:0] usable_reg;
    logic [COUNT_W-1:0] pages_reg;
    logic mode_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [WADDR_W:0] waddr_reg, waddr_next;
    logic [COUNT_W:0] limit;
    logic found_reg;
    logic [COUNT_W-1:0] chosen_reg;
    logic m_valid_reg;
    logic res_found_reg;
    logic [COUNT_W-1:0] res_page_reg;

    logic ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [WORD_W-1:0] word_reg;
    logic [LANES-1:0] hit_now;
    logic [LANES-1:0] hit_reg;
    logic [LANE_W-1:0] lane_sel;
    logic any_hit;

    fsm_ff_ram #(.DEPTH(WORDS), .WIDTH(WORD_W)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(waddr_reg[WADDR_W-1:0]), .rdata(ram_rdata)
    );

    assign limit = (pages_reg > COUNT_W'(MAX_PAGES)) ? (COUNT_W+1)'(MAX_PAGES)
                                                     : {1'b0, pages_reg};

    // Lanes that fit and lie below the page limit; lowest one wins.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            hit_now[i] = ((COUNT_W+1)'({waddr_reg[WADDR_W-1:0], LANE_W'(i)}) < limit) &&
                (class_threshold(usable_reg, ram_rdata[i*CLASS_W +: CLASS_W]) >= bytes_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            hit_reg <= hit_now;
            word_reg <= ram_rdata;
        end
    end

    always_comb begin
        lane_sel = '0;
        for (int i = LANES-1; i >= 0; i--) begin
            if (hit_reg[i]) lane_sel = LANE_W'(i);
        end
    end
    assign any_hit = |hit_now;

    logic [BYTES_W-1:0] have;
    assign have = class_threshold(usable_reg, word_reg[lane_sel*CLASS_W +: CLASS_W]);

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = waddr_reg[WADDR_W-1:0];
        ram_wdata = word_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
            ram_wdata = {LANES{CLASS_FREE}};
        end else if (state_reg == ST_WRITE) begin
            ram_we = 1'b1;
            if (mode_reg == MODE_UPDATE) begin
                ram_wdata[page_reg[LANE_W-1:0]*CLASS_W +: CLASS_W] =
                    encode_class(usable_reg, bytes_reg);
            end else begin
                ram_wdata[lane_sel*CLASS_W +: CLASS_W] =
                    encode_class(usable_reg, have - bytes_reg);
            end
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_found = found_reg;
    assign m_chosen_page = chosen_reg;

    always_comb begin
        state_next = state_reg;
        waddr_next = waddr_reg;
        case (state_reg)
            ST_CLEAR: begin
                waddr_next = waddr_reg + 1'b1;
                if (waddr_reg == (WADDR_W+1)'(WORDS-1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_mode == MODE_UPDATE) begin
                        waddr_next = {1'b0, s_page_index[PAGE_W-1:LANE_W]};
                        if ({1'b0, s_page_index} < limit) state_next = ST_READ;
                    end else begin
                        waddr_next = '0;
                        state_next = (limit == '0) ? ST_OUT : ST_READ;
                    end
                end
            end
            ST_READ: state_next = ST_CHECK;
            ST_CHECK: begin
                if (mode_reg == MODE_UPDATE || any_hit) begin
                    state_next = ST_WRITE;
                end else if ((COUNT_W+1)'({waddr_reg[WADDR_W-1:0], LANE_W'(0)}) +
                             (COUNT_W+1)'(LANES) >= limit) begin
                    state_next = ST_OUT;
                end else begin
                    waddr_next = waddr_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_WRITE: state_next = (mode_reg == MODE_UPDATE) ? ST_IDLE : ST_OUT;
            // The answer waits here until the output register is free.
            ST_OUT: state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            waddr_reg <= '0;
            usable_reg <= BYTES_W'(4064);
            pages_reg <= '0;
            m_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            chosen_reg <= '0;
        end else begin
            state_reg <= state_next;
            waddr_reg <= waddr_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_USABLE) usable_reg <= cfg_data;
                else pages_reg <= cfg_data[COUNT_W-1:0];
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                found_reg <= res_found_reg;
                chosen_reg <= res_page_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_ready) begin
            mode_reg <= s_mode;
            page_reg <= s_page_index;
            bytes_reg <= (s_mode == MODE_UPDATE) ? s_free_space : s_required_space;
        end
        if (state_next == ST_OUT && state_reg != ST_OUT) begin
            if (state_reg == ST_WRITE) begin
                res_found_reg <= 1'b1;
                res_page_reg <= COUNT_W'({waddr_reg[WADDR_W-1:0], lane_sel});
            end else begin
                res_found_reg <= 1'b0;
                res_page_reg <= pages_reg;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_found) && $stable(m_chosen_page)))
        else $error("result dropped or changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_valid) else $error("result not raised");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("stray memory write");
endmodule
`default_nettype wire
